// ===== src/kmc_pkg.sv =====
package kmc_pkg;

  // Field and store widths
  localparam int PI_W     = 10;
  localparam int CL_W     = 4;
  localparam int CO_W     = 4;
  localparam int COORD_W  = 32;
  localparam int NP_W     = 11;
  localparam int NK_W     = 5;
  localparam int ND_W     = 5;
  localparam int IT_W     = 8;
  localparam int THR_W    = 32;
  localparam int SUM_W    = 48;
  localparam int SQ_W     = 2 * (COORD_W + 1);
  localparam int DIST_W   = 72;
  localparam int SHIFT_W  = 48;
  localparam int CNT_W    = 11;
  localparam int DIV_W    = SUM_W + 1;
  localparam int DIV_CW   = 6;
  localparam int PM_AW    = PI_W + CO_W;
  localparam int CM_AW    = CL_W + CO_W;
  localparam int MAX_PTS  = 1024;
  localparam int MAX_CLS  = 16;
  localparam int MAX_DIMS = 16;

  // Reset values of the configuration registers
  localparam logic [NP_W-1:0]  NUM_POINTS_RST = NP_W'(1024);
  localparam logic [NK_W-1:0]  NUM_CLS_RST    = NK_W'(16);
  localparam logic [ND_W-1:0]  DIMS_RST       = ND_W'(16);
  localparam logic [IT_W-1:0]  MAX_IT_RST     = IT_W'(100);
  localparam logic [THR_W-1:0] THR_RST        = THR_W'(4356);

  typedef enum logic [2:0] {
    OP_LOAD_POINT  = 3'd0,
    OP_LOAD_CENTER = 3'd1,
    OP_RUN         = 3'd2,
    OP_READ_ASSIGN = 3'd3,
    OP_READ_CENTER = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    REG_NUM_POINTS = 3'd0,
    REG_NUM_CLS    = 3'd1,
    REG_DIMS       = 3'd2,
    REG_MAX_IT     = 3'd3,
    REG_THRESHOLD  = 3'd4
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RESP,
    ST_RUN_INIT,
    ST_CLR,
    ST_AS_ISSUE,
    ST_AS_DRAIN,
    ST_ACC_ISSUE,
    ST_ACC_DRAIN,
    ST_U_CHK,
    ST_U_RD,
    ST_U_DIV_START,
    ST_U_DIV_WAIT,
    ST_U_MUL,
    ST_U_ACC,
    ST_ROUND_END
  } ctrl_state_t;

  // Clamped configuration, counts kept as last index
  typedef struct packed {
    logic [PI_W-1:0]  np_m1;
    logic [CL_W-1:0]  nk_m1;
    logic [CO_W-1:0]  nd_m1;
    logic [IT_W-1:0]  max_it;
    logic [THR_W-1:0] thr;
  } cfg_t;

  typedef struct packed {
    logic             accept;
    logic             res_load;
    logic             stat_clear;
    logic             stat_commit;
    logic             round_start;
    logic             sm_clr_we;
    logic [CM_AW-1:0] clr_addr;
    logic             as_issue;
    logic             acc_issue;
    logic             acc_first;
    logic             upd_rd;
    logic             div_start;
    logic             upd_mul;
    logic             upd_acc;
    logic             first;
    logic             last;
    logic [PI_W-1:0]  i;
    logic [CL_W-1:0]  k;
    logic [CO_W-1:0]  d;
    logic [IT_W-1:0]  it;
  } dp_cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic div_done;
    logic conv;
  } dp_stat_t;

  // Exact square of the difference of two signed coordinates
  function automatic logic [SQ_W-1:0] sq_diff(input logic [COORD_W-1:0] a,
                                              input logic [COORD_W-1:0] b);
    logic [COORD_W:0] diff;
    logic [COORD_W:0] mag;
    diff = {a[COORD_W-1], a} - {b[COORD_W-1], b};
    mag  = diff[COORD_W] ? (~diff + 1'b1) : diff;
    return mag * mag;
  endfunction

endpackage

// ===== src/kmc_div.sv =====
module kmc_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [kmc_pkg::DIV_W-1:0]  dividend,
  input  logic [kmc_pkg::CNT_W-1:0]  divisor,
  output logic [kmc_pkg::DIV_W-1:0]  quotient,
  output logic                       done
);
  import kmc_pkg::*;

  logic [DIV_W-1:0]  quo_r;
  logic [CNT_W-1:0]  rem_r;
  logic [DIV_CW-1:0] cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [CNT_W:0]    trial;
  logic              ge;
  logic [CNT_W:0]    diff;

  // One quotient bit per cycle, restoring
  always_comb begin
    trial = {rem_r, quo_r[DIV_W-1]};
    ge    = trial >= {1'b0, divisor};
    diff  = trial - {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= DIV_CW'(DIV_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == DIV_CW'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
    end else if (busy_r) begin
      quo_r <= {quo_r[DIV_W-2:0], ge};
      rem_r <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
    end
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule

// ===== src/kmc_dp.sv =====
module kmc_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  kmc_pkg::cfg_t                 cfg,
  input  kmc_pkg::dp_cmd_t              cmd,
  output kmc_pkg::dp_stat_t             stat,
  input  logic [2:0]                    in_op,
  input  logic [kmc_pkg::PI_W-1:0]      in_point_index,
  input  logic [kmc_pkg::CL_W-1:0]      in_cluster_index,
  input  logic [kmc_pkg::CO_W-1:0]      in_coord_index,
  input  logic signed [kmc_pkg::COORD_W-1:0] in_coord_value,
  output logic signed [kmc_pkg::COORD_W-1:0] out_read_value,
  output logic [kmc_pkg::CL_W-1:0]      out_cluster_id,
  output logic [kmc_pkg::IT_W-1:0]      out_iterations_used,
  output logic                          out_converged,
  output logic [kmc_pkg::SHIFT_W-1:0]   out_max_shift_sq,
  output logic                          out_index_error
);
  import kmc_pkg::*;

  // Stores
  logic [COORD_W-1:0] pmem [MAX_PTS*MAX_DIMS];
  logic [COORD_W-1:0] cmem [MAX_CLS*MAX_DIMS];
  logic [SUM_W-1:0]   smem [MAX_CLS*MAX_DIMS];
  logic [CL_W-1:0]    amem [MAX_PTS];
  logic [COORD_W-1:0] pt_q, cm_q;
  logic [SUM_W-1:0]   sm_q;
  logic [CL_W-1:0]    am_q;
  logic [NP_W-1:0]    fill_r;
  logic [CNT_W-1:0]   cnt_r [MAX_CLS];

  // Item registers
  logic [2:0]         op_q;
  logic [PI_W-1:0]    pi_q;
  logic               bad_q;
  logic               in_bad;
  logic               pbad, cbad, dbad;

  // Distance pipeline
  logic               s1_v_r, s1_first_r, s1_last_r;
  logic [CL_W-1:0]    s1_k_r;
  logic               s2_v_r, s2_first_r, s2_last_r;
  logic [CL_W-1:0]    s2_k_r;
  logic [SQ_W-1:0]    prod_r;
  logic [DIST_W-1:0]  acc_r, best_r, as_total;
  logic [CL_W-1:0]    bestk_r;
  logic               aw_v_r;
  logic [CM_AW-1:0]   aw_addr_r;

  // Center update
  logic               neg_r;
  logic [COORD_W-1:0] nc_r, nc;
  logic [DIST_W-1:0]  shacc_r, worst_r, sh_total;
  logic [COORD_W-1:0] mul_a;
  logic [CNT_W-1:0]   cnt_k;
  logic [SUM_W-1:0]   sum_mag;
  logic [DIV_W-1:0]   dividend, quotient;
  logic               div_done;

  // Status and result
  logic [IT_W-1:0]    st_iters_r;
  logic               st_conv_r;
  logic [SHIFT_W-1:0] st_shift_r;
  logic [COORD_W-1:0] rv_r;
  logic [CL_W-1:0]    cid_r;
  logic               err_r;
  logic               conv;
  logic [SHIFT_W-1:0] shift_sat;

  // Index checks on the incoming beat
  always_comb begin
    pbad = in_point_index > cfg.np_m1;
    cbad = in_cluster_index > cfg.nk_m1;
    dbad = in_coord_index > cfg.nd_m1;
    case (op_t'(in_op))
      OP_LOAD_POINT:  in_bad = pbad | dbad;
      OP_LOAD_CENTER: in_bad = cbad | dbad;
      OP_READ_ASSIGN: in_bad = pbad;
      OP_READ_CENTER: in_bad = cbad | dbad;
      default:        in_bad = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_q  <= in_op;
      pi_q  <= in_point_index;
      bad_q <= in_bad;
    end
  end

  // Point store
  always_ff @(posedge clk) begin
    if (cmd.accept && op_t'(in_op) == OP_LOAD_POINT && !in_bad)
      pmem[{in_point_index, in_coord_index}] <= in_coord_value;
    if (cmd.as_issue || cmd.acc_issue)
      pt_q <= pmem[{cmd.i, cmd.d}];
  end

  // Center store
  always_ff @(posedge clk) begin
    if (cmd.accept && op_t'(in_op) == OP_LOAD_CENTER && !in_bad)
      cmem[{in_cluster_index, in_coord_index}] <= in_coord_value;
    else if (cmd.upd_acc)
      cmem[{cmd.k, cmd.d}] <= nc_r;
    if (cmd.accept)
      cm_q <= cmem[{in_cluster_index, in_coord_index}];
    else if (cmd.as_issue || cmd.upd_rd)
      cm_q <= cmem[{cmd.k, cmd.d}];
  end

  // Sum store: clear sweep, read-modify-write accumulate
  always_ff @(posedge clk) begin
    if (cmd.sm_clr_we)
      smem[cmd.clr_addr] <= '0;
    else if (aw_v_r)
      smem[aw_addr_r] <= sm_q + {{(SUM_W-COORD_W){pt_q[COORD_W-1]}}, pt_q};
    if (cmd.acc_issue)
      sm_q <= smem[{bestk_r, cmd.d}];
    else if (cmd.upd_rd)
      sm_q <= smem[{cmd.k, cmd.d}];
  end

  always_ff @(posedge clk) begin
    aw_addr_r <= {bestk_r, cmd.d};
  end

  // Assignment store
  always_ff @(posedge clk) begin
    if (cmd.acc_issue && cmd.acc_first)
      amem[cmd.i] <= bestk_r;
    if (cmd.accept)
      am_q <= amem[in_point_index];
  end

  // Control state: valid bits, fill mark, member counts
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      aw_v_r <= 1'b0;
      fill_r <= '0;
      for (int j = 0; j < MAX_CLS; j++) cnt_r[j] <= '0;
    end else begin
      s1_v_r <= cmd.as_issue;
      s2_v_r <= s1_v_r;
      aw_v_r <= cmd.acc_issue;
      if (cmd.acc_issue && cmd.acc_first && {1'b0, cmd.i} >= fill_r)
        fill_r <= {1'b0, cmd.i} + 1'b1;
      for (int j = 0; j < MAX_CLS; j++) begin
        if (cmd.round_start)
          cnt_r[j] <= '0;
        else if (cmd.acc_issue && cmd.acc_first && bestk_r == CL_W'(j))
          cnt_r[j] <= cnt_r[j] + 1'b1;
      end
    end
  end

  // Shared squarer: point vs center, or old vs new center
  assign mul_a = s1_v_r ? pt_q : nc;

  always_ff @(posedge clk) begin
    s1_first_r <= cmd.first;
    s1_last_r  <= cmd.last;
    s1_k_r     <= cmd.k;
    s2_first_r <= s1_first_r;
    s2_last_r  <= s1_last_r;
    s2_k_r     <= s1_k_r;
    if (s1_v_r || cmd.upd_mul)
      prod_r <= sq_diff(mul_a, cm_q);
  end

  // Distance accumulate and nearest-center pick
  assign as_total = (s2_first_r ? '0 : acc_r) + DIST_W'(prod_r);

  always_ff @(posedge clk) begin
    if (s2_v_r) begin
      acc_r <= as_total;
      if (s2_last_r && (s2_k_r == '0 || as_total < best_r)) begin
        best_r  <= as_total;
        bestk_r <= s2_k_r;
      end
    end
  end

  // Mean by divider, rounded half away from zero
  assign cnt_k    = cnt_r[cmd.k];
  assign sum_mag  = sm_q[SUM_W-1] ? (~sm_q + 1'b1) : sm_q;
  assign dividend = {1'b0, sum_mag} + DIV_W'(cnt_k >> 1);
  assign nc       = neg_r ? (~quotient[COORD_W-1:0] + 1'b1) : quotient[COORD_W-1:0];

  kmc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (cnt_k),
    .quotient (quotient),
    .done     (div_done)
  );

  assign sh_total = (cmd.first ? '0 : shacc_r) + DIST_W'(prod_r);

  always_ff @(posedge clk) begin
    if (cmd.div_start) neg_r <= sm_q[SUM_W-1];
    if (cmd.upd_mul)   nc_r  <= nc;
    if (cmd.upd_acc)   shacc_r <= sh_total;
    if (cmd.round_start)
      worst_r <= '0;
    else if (cmd.upd_acc && cmd.last && worst_r < sh_total)
      worst_r <= sh_total;
  end

  // Run status
  assign conv      = worst_r < DIST_W'(cfg.thr);
  assign shift_sat = (worst_r > DIST_W'({SHIFT_W{1'b1}})) ? {SHIFT_W{1'b1}}
                                                           : worst_r[SHIFT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.stat_clear) begin
      st_iters_r <= '0;
      st_conv_r  <= 1'b0;
      st_shift_r <= '0;
    end else if (cmd.stat_commit) begin
      st_iters_r <= cmd.it + 1'b1;
      st_conv_r  <= conv;
      st_shift_r <= shift_sat;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      rv_r  <= '0;
      cid_r <= '0;
      err_r <= 1'b0;
      case (op_t'(op_q))
        OP_LOAD_POINT, OP_LOAD_CENTER: err_r <= bad_q;
        OP_READ_ASSIGN: begin
          err_r <= bad_q;
          if (!bad_q && {1'b0, pi_q} < fill_r) cid_r <= am_q;
        end
        OP_READ_CENTER: begin
          err_r <= bad_q;
          if (!bad_q) rv_r <= cm_q;
        end
        default: ;
      endcase
    end
  end

  assign stat.cnt_zero = cnt_k == '0;
  assign stat.div_done = div_done;
  assign stat.conv     = conv;

  assign out_read_value      = rv_r;
  assign out_cluster_id      = cid_r;
  assign out_index_error     = err_r;
  assign out_iterations_used = st_iters_r;
  assign out_converged       = st_conv_r;
  assign out_max_shift_sq    = st_shift_r;

endmodule

// ===== src/kmc_ctrl.sv =====
module kmc_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  kmc_pkg::cfg_t        cfg,
  input  kmc_pkg::dp_stat_t    stat,
  output kmc_pkg::dp_cmd_t     cmd,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [2:0]           in_op,
  output logic                 out_valid,
  input  logic                 out_ready
);
  import kmc_pkg::*;

  ctrl_state_t       state_r, state_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [IT_W-1:0]   it_r, it_nxt;
  logic [PI_W-1:0]   i_r, i_nxt;
  logic [CL_W-1:0]   k_r, k_nxt;
  logic [CO_W-1:0]   d_r, d_nxt;
  logic [CM_AW-1:0]  clr_r, clr_nxt;
  logic              drain_r, drain_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      it_r        <= '0;
      i_r         <= '0;
      k_r         <= '0;
      d_r         <= '0;
      clr_r       <= '0;
      drain_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      it_r        <= it_nxt;
      i_r         <= i_nxt;
      k_r         <= k_nxt;
      d_r         <= d_nxt;
      clr_r       <= clr_nxt;
      drain_r     <= drain_nxt;
    end
  end

  // Sequencer: clear, assign, accumulate, update per round
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    it_nxt        = it_r;
    i_nxt         = i_r;
    k_nxt         = k_r;
    d_nxt         = d_r;
    clr_nxt       = clr_r;
    drain_nxt     = drain_r;
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.i         = i_r;
    cmd.k         = k_r;
    cmd.d         = d_r;
    cmd.it        = it_r;
    cmd.clr_addr  = clr_r;
    cmd.first     = d_r == '0;
    cmd.last      = d_r == cfg.nd_m1;

    case (state_r)
      ST_IDLE: begin
        in_ready = !out_valid_r || out_ready;
        if (in_valid && in_ready) begin
          cmd.accept = 1'b1;
          state_nxt  = (op_t'(in_op) == OP_RUN) ? ST_RUN_INIT : ST_RESP;
        end
      end
      ST_RESP: begin
        cmd.res_load  = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      ST_RUN_INIT: begin
        cmd.stat_clear = 1'b1;
        if (cfg.max_it == '0) begin
          state_nxt = ST_RESP;
        end else begin
          cmd.round_start = 1'b1;
          it_nxt    = '0;
          clr_nxt   = '0;
          state_nxt = ST_CLR;
        end
      end
      ST_CLR: begin
        cmd.sm_clr_we = 1'b1;
        clr_nxt       = clr_r + 1'b1;
        if (&clr_r) begin
          i_nxt     = '0;
          k_nxt     = '0;
          d_nxt     = '0;
          state_nxt = ST_AS_ISSUE;
        end
      end
      ST_AS_ISSUE: begin
        cmd.as_issue = 1'b1;
        if (d_r == cfg.nd_m1) begin
          d_nxt = '0;
          if (k_r == cfg.nk_m1) begin
            k_nxt     = '0;
            drain_nxt = 1'b0;
            state_nxt = ST_AS_DRAIN;
          end else begin
            k_nxt = k_r + 1'b1;
          end
        end else begin
          d_nxt = d_r + 1'b1;
        end
      end
      ST_AS_DRAIN: begin
        drain_nxt = 1'b1;
        if (drain_r) state_nxt = ST_ACC_ISSUE;
      end
      ST_ACC_ISSUE: begin
        cmd.acc_issue = 1'b1;
        cmd.acc_first = d_r == '0;
        if (d_r == cfg.nd_m1) begin
          d_nxt     = '0;
          state_nxt = ST_ACC_DRAIN;
        end else begin
          d_nxt = d_r + 1'b1;
        end
      end
      ST_ACC_DRAIN: begin
        if (i_r == cfg.np_m1) begin
          i_nxt     = '0;
          k_nxt     = '0;
          state_nxt = ST_U_CHK;
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = ST_AS_ISSUE;
        end
      end
      ST_U_CHK: begin
        d_nxt = '0;
        if (!stat.cnt_zero)        state_nxt = ST_U_RD;
        else if (k_r == cfg.nk_m1) state_nxt = ST_ROUND_END;
        else                       k_nxt = k_r + 1'b1;
      end
      ST_U_RD: begin
        cmd.upd_rd = 1'b1;
        state_nxt  = ST_U_DIV_START;
      end
      ST_U_DIV_START: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_U_DIV_WAIT;
      end
      ST_U_DIV_WAIT: begin
        if (stat.div_done) state_nxt = ST_U_MUL;
      end
      ST_U_MUL: begin
        cmd.upd_mul = 1'b1;
        state_nxt   = ST_U_ACC;
      end
      ST_U_ACC: begin
        cmd.upd_acc = 1'b1;
        if (d_r == cfg.nd_m1) begin
          d_nxt = '0;
          if (k_r == cfg.nk_m1) begin
            state_nxt = ST_ROUND_END;
          end else begin
            k_nxt     = k_r + 1'b1;
            state_nxt = ST_U_CHK;
          end
        end else begin
          d_nxt     = d_r + 1'b1;
          state_nxt = ST_U_RD;
        end
      end
      ST_ROUND_END: begin
        cmd.stat_commit = 1'b1;
        if (stat.conv || (it_r + 1'b1) == cfg.max_it) begin
          state_nxt = ST_RESP;
        end else begin
          cmd.round_start = 1'b1;
          it_nxt    = it_r + 1'b1;
          clr_nxt   = '0;
          state_nxt = ST_CLR;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

// ===== src/kmeans_clustering_engine_unit.sv =====
// Lloyd k-means engine on signed Q16.16 vectors. Load, read and unknown-op
// items are accepted, then their result beat is registered. A run item,
// per round, clears all 256 entries of the sum store, then for every point
// does the distance work and then the sum accumulation, then for every
// non-empty cluster divides each coordinate sum by the member count (one
// quotient bit per cycle from the divider). The single read port of the
// point and center stores sets the distance loop rate; the divider sets the
// update rate. Rounds repeat up to max_iterations or until the largest
// squared center shift falls below shift_threshold_sq.
module kmeans_clustering_engine_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [2:0]                         in_op,
  input  logic [kmc_pkg::PI_W-1:0]           in_point_index,
  input  logic [kmc_pkg::CL_W-1:0]           in_cluster_index,
  input  logic [kmc_pkg::CO_W-1:0]           in_coord_index,
  input  logic signed [kmc_pkg::COORD_W-1:0] in_coord_value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [kmc_pkg::COORD_W-1:0] out_read_value,
  output logic [kmc_pkg::CL_W-1:0]           out_cluster_id,
  output logic [kmc_pkg::IT_W-1:0]           out_iterations_used,
  output logic                               out_converged,
  output logic [kmc_pkg::SHIFT_W-1:0]        out_max_shift_sq,
  output logic                               out_index_error,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [4:0]                         paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);
  import kmc_pkg::*;

  logic [NP_W-1:0]  num_points_r;
  logic [NK_W-1:0]  num_cls_r;
  logic [ND_W-1:0]  dims_r;
  logic [IT_W-1:0]  max_it_r;
  logic [THR_W-1:0] thr_r;
  logic             wr_en;
  cfg_t             cfg;
  dp_cmd_t          cmd;
  dp_stat_t         stat;

  // Register writes
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_points_r <= NUM_POINTS_RST;
      num_cls_r    <= NUM_CLS_RST;
      dims_r       <= DIMS_RST;
      max_it_r     <= MAX_IT_RST;
      thr_r        <= THR_RST;
    end else if (wr_en) begin
      case (reg_idx_t'(paddr[4:2]))
        REG_NUM_POINTS: num_points_r <= pwdata[NP_W-1:0];
        REG_NUM_CLS:    num_cls_r    <= pwdata[NK_W-1:0];
        REG_DIMS:       dims_r       <= pwdata[ND_W-1:0];
        REG_MAX_IT:     max_it_r     <= pwdata[IT_W-1:0];
        REG_THRESHOLD:  thr_r        <= pwdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    case (reg_idx_t'(paddr[4:2]))
      REG_NUM_POINTS: prdata = 32'(num_points_r);
      REG_NUM_CLS:    prdata = 32'(num_cls_r);
      REG_DIMS:       prdata = 32'(dims_r);
      REG_MAX_IT:     prdata = 32'(max_it_r);
      REG_THRESHOLD:  prdata = thr_r;
      default:        prdata = '0;
    endcase
  end

  // Clamp counts into 1..max, kept as last index
  always_comb begin
    if (num_points_r == '0)                  cfg.np_m1 = '0;
    else if (num_points_r > NP_W'(MAX_PTS))  cfg.np_m1 = PI_W'(MAX_PTS - 1);
    else                                     cfg.np_m1 = PI_W'(num_points_r - 1'b1);
    if (num_cls_r == '0)                     cfg.nk_m1 = '0;
    else if (num_cls_r > NK_W'(MAX_CLS))     cfg.nk_m1 = CL_W'(MAX_CLS - 1);
    else                                     cfg.nk_m1 = CL_W'(num_cls_r - 1'b1);
    if (dims_r == '0)                        cfg.nd_m1 = '0;
    else if (dims_r > ND_W'(MAX_DIMS))       cfg.nd_m1 = CO_W'(MAX_DIMS - 1);
    else                                     cfg.nd_m1 = CO_W'(dims_r - 1'b1);
    cfg.max_it = max_it_r;
    cfg.thr    = thr_r;
  end

  kmc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .stat      (stat),
    .cmd       (cmd),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_op     (in_op),
    .out_valid (out_valid),
    .out_ready (out_ready)
  );

  kmc_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg                 (cfg),
    .cmd                 (cmd),
    .stat                (stat),
    .in_op               (in_op),
    .in_point_index      (in_point_index),
    .in_cluster_index    (in_cluster_index),
    .in_coord_index      (in_coord_index),
    .in_coord_value      (in_coord_value),
    .out_read_value      (out_read_value),
    .out_cluster_id      (out_cluster_id),
    .out_iterations_used (out_iterations_used),
    .out_converged       (out_converged),
    .out_max_shift_sq    (out_max_shift_sq),
    .out_index_error     (out_index_error)
  );

endmodule

// ===== src/kmc_checker.sv =====
module kmc_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic signed [kmc_pkg::COORD_W-1:0] out_read_value,
  input logic [kmc_pkg::CL_W-1:0]           out_cluster_id,
  input logic [kmc_pkg::IT_W-1:0]           out_iterations_used,
  input logic                               out_converged,
  input logic [kmc_pkg::SHIFT_W-1:0]        out_max_shift_sq,
  input logic                               out_index_error
);

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_read_value)
      && $stable(out_cluster_id) && $stable(out_index_error))
    else $error("result beat changed while stalled");

  // One item in flight: no accept right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted back to back");

  // A beat never carries both a center value and an assignment
  a_one_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_read_value == '0 || out_cluster_id == '0)
    else $error("center value and assignment both set");

  // Convergence implies at least one round
  a_conv_rounds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_converged |-> out_iterations_used != '0)
    else $error("converged with no round");

endmodule

bind kmeans_clustering_engine_unit kmc_checker u_kmc_checker (.*);

// ===== dv/tb_kmeans_clustering_engine_unit.sv =====
`timescale 1ns / 1ps

module tb_kmeans_clustering_engine_unit;
  import kmc_pkg::*;

  localparam int NO_PROGRESS_LIMIT = 200000;

  typedef struct {
    logic [2:0]  op;
    logic [9:0]  pi;
    logic [3:0]  ci;
    logic [3:0]  di;
    logic [31:0] val;
  } job_t;

  typedef struct {
    logic [31:0] rv;
    logic [3:0]  cid;
    logic [7:0]  iters;
    logic        conv;
    logic [47:0] shift;
    logic        err;
  } res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] in_op = '0;
  logic [PI_W-1:0] in_point_index = '0;
  logic [CL_W-1:0] in_cluster_index = '0;
  logic [CO_W-1:0] in_coord_index = '0;
  logic signed [COORD_W-1:0] in_coord_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [COORD_W-1:0] out_read_value;
  logic [CL_W-1:0] out_cluster_id;
  logic [IT_W-1:0] out_iterations_used;
  logic out_converged;
  logic [SHIFT_W-1:0] out_max_shift_sq;
  logic out_index_error;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  kmeans_clustering_engine_unit uut (.*);

  always #1 clk = ~clk;

  // predictor state
  int          pt_mem [0:16383];
  int          ctr_mem [0:255];
  bit [3:0]    asg_mem [0:1023];
  logic [10:0] cfg_np = 11'd1024;
  logic [4:0]  cfg_nk = 5'd16;
  logic [4:0]  cfg_nd = 5'd16;
  logic [7:0]  cfg_it = 8'd100;
  logic [31:0] cfg_thr = 32'd4356;
  logic [7:0]  st_iters = '0;
  logic        st_conv = 1'b0;
  logic [47:0] st_shift = '0;

  // stimulus-side bookkeeping of which store entries hold data
  bit pt_set [0:16383];
  bit ctr_set [0:255];

  job_t pending_jobs[$];
  res_t expected_res[$];
  int   mismatches = 0;
  int   idle_cycles = 0;
  int   in_gap = 0;
  int   out_stall = 0;
  bit   in_burst = 1'b0;
  bit   out_burst = 1'b0;
  int   job_count = 0;

  function automatic int eff(int v, int hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [71:0] sq_term(longint a, longint b);
    longint      d;
    logic [71:0] m;
    d = a - b;
    m = (d < 0) ? 72'(-d) : 72'(d);
    return m * m;
  endfunction

  function automatic int round_mean(longint s, int cnt);
    longint q;
    q = ((s < 0 ? -s : s) + cnt / 2) / cnt;
    return (s < 0) ? int'(-q) : int'(q);
  endfunction

  // Lloyd rounds over the model stores
  task automatic cluster_run();
    int np, nk, nd, bk;
    logic [71:0] worst, best, dd, sh;
    longint sums [0:255];
    int cnt [0:15];
    int nc [0:15];
    np = eff(cfg_np, MAX_PTS);
    nk = eff(cfg_nk, MAX_CLS);
    nd = eff(cfg_nd, MAX_DIMS);
    st_iters = '0; st_conv = 1'b0; st_shift = '0;
    for (int it = 0; it < cfg_it; it++) begin
      worst = '0;
      for (int i = 0; i < np; i++) begin
        bk = 0;
        for (int k = 0; k < nk; k++) begin
          dd = '0;
          for (int d = 0; d < nd; d++) dd += sq_term(pt_mem[i*16+d], ctr_mem[k*16+d]);
          if (k == 0 || dd < best) begin
            best = dd;
            bk = k;
          end
        end
        asg_mem[i] = 4'(bk);
      end
      foreach (sums[x]) sums[x] = 0;
      foreach (cnt[x]) cnt[x] = 0;
      for (int i = 0; i < np; i++) begin
        cnt[asg_mem[i]]++;
        for (int d = 0; d < nd; d++) sums[asg_mem[i]*16+d] += pt_mem[i*16+d];
      end
      for (int k = 0; k < nk; k++) begin
        if (cnt[k] != 0) begin
          sh = '0;
          for (int d = 0; d < nd; d++) begin
            nc[d] = round_mean(sums[k*16+d], cnt[k]);
            sh += sq_term(ctr_mem[k*16+d], nc[d]);
          end
          if (sh > worst) worst = sh;
          for (int d = 0; d < nd; d++) ctr_mem[k*16+d] = nc[d];
        end
      end
      st_iters = 8'(it + 1);
      st_shift = (worst > 72'hFFFF_FFFF_FFFF) ? 48'hFFFF_FFFF_FFFF : worst[47:0];
      if (worst < {40'd0, cfg_thr}) begin
        st_conv = 1'b1;
        break;
      end
    end
  endtask

  task automatic kmeans_step(input job_t j, output res_t r);
    bit pbad, cbad, dbad;
    pbad = j.pi >= eff(cfg_np, MAX_PTS);
    cbad = j.ci >= eff(cfg_nk, MAX_CLS);
    dbad = j.di >= eff(cfg_nd, MAX_DIMS);
    r.rv = '0; r.cid = '0; r.err = 1'b0;
    case (j.op)
      OP_LOAD_POINT: begin
        if (pbad || dbad) r.err = 1'b1;
        else pt_mem[j.pi*16+j.di] = j.val;
      end
      OP_LOAD_CENTER: begin
        if (cbad || dbad) r.err = 1'b1;
        else ctr_mem[j.ci*16+j.di] = j.val;
      end
      OP_RUN: cluster_run();
      OP_READ_ASSIGN: begin
        if (pbad) r.err = 1'b1;
        else r.cid = asg_mem[j.pi];
      end
      OP_READ_CENTER: begin
        if (cbad || dbad) r.err = 1'b1;
        else r.rv = ctr_mem[j.ci*16+j.di];
      end
      default: ;
    endcase
    r.iters = st_iters; r.conv = st_conv; r.shift = st_shift;
  endtask

  function automatic int draw_gap(inout bit burst);
    if ($urandom_range(0, 19) == 0) burst = ~burst;
    return burst ? 0 : $urandom_range(0, 18);
  endfunction

  // input driver: predicts each accepted beat, then presents the next one
  always @(posedge clk) begin
    res_t r;
    job_t j;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        j = '{in_op, in_point_index, in_cluster_index, in_coord_index, in_coord_value};
        kmeans_step(j, r);
        expected_res.push_back(r);
      end
      if (in_valid && !in_ready) begin
        // hold the beat
      end else if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (pending_jobs.size() > 0) begin
        j = pending_jobs.pop_front();
        in_op <= j.op;
        in_point_index <= j.pi;
        in_cluster_index <= j.ci;
        in_coord_index <= j.di;
        in_coord_value <= j.val;
        in_valid <= 1'b1;
        in_gap = draw_gap(in_burst);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result monitor and ready stalls
  always @(posedge clk) begin
    res_t e;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_res.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result beat at %0t", $realtime);
        end else begin
          e = expected_res.pop_front();
          if (out_read_value !== e.rv || out_cluster_id !== e.cid ||
              out_iterations_used !== e.iters || out_converged !== e.conv ||
              out_max_shift_sq !== e.shift || out_index_error !== e.err) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch at %0t: exp rv=%h cid=%0d it=%0d conv=%b sh=%h err=%b",
                       $realtime, e.rv, e.cid, e.iters, e.conv, e.shift, e.err,
                       " got rv=%h cid=%0d it=%0d conv=%b sh=%h err=%b",
                       out_read_value, out_cluster_id, out_iterations_used,
                       out_converged, out_max_shift_sq, out_index_error);
          end
        end
        out_stall = draw_gap(out_burst);
      end else if (out_stall > 0) begin
        out_stall--;
      end
      out_ready <= (out_stall == 0);
    end
  end

  // watchdog on cycles without any beat or register access
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || psel) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= NO_PROGRESS_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic cfg_write(input reg_idx_t idx, input logic [31:0] v);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_NUM_POINTS: cfg_np = v[10:0];
      REG_NUM_CLS:    cfg_nk = v[4:0];
      REG_DIMS:       cfg_nd = v[4:0];
      REG_MAX_IT:     cfg_it = v[7:0];
      default:        cfg_thr = v;
    endcase
  endtask

  task automatic set_all(int np, int nk, int nd, int it, logic [31:0] thr);
    cfg_write(REG_NUM_POINTS, np);
    cfg_write(REG_NUM_CLS, nk);
    cfg_write(REG_DIMS, nd);
    cfg_write(REG_MAX_IT, it);
    cfg_write(REG_THRESHOLD, thr);
  endtask

  task automatic push_job(logic [2:0] op, int pi, int ci, int di, logic [31:0] val);
    bit dok;
    dok = di < eff(cfg_nd, MAX_DIMS);
    if (op == OP_LOAD_POINT && pi < eff(cfg_np, MAX_PTS) && dok) pt_set[pi*16+di] = 1'b1;
    if (op == OP_LOAD_CENTER && ci < eff(cfg_nk, MAX_CLS) && dok) ctr_set[ci*16+di] = 1'b1;
    pending_jobs.push_back('{op, 10'(pi), 4'(ci), 4'(di), val});
    job_count++;
  endtask

  function automatic bit stores_ready();
    for (int i = 0; i < eff(cfg_np, MAX_PTS); i++)
      for (int d = 0; d < eff(cfg_nd, MAX_DIMS); d++)
        if (!pt_set[i*16+d]) return 0;
    for (int k = 0; k < eff(cfg_nk, MAX_CLS); k++)
      for (int d = 0; d < eff(cfg_nd, MAX_DIMS); d++)
        if (!ctr_set[k*16+d]) return 0;
    return 1;
  endfunction

  // random item that never touches an unwritten entry
  task automatic push_noise();
    logic [2:0] op;
    int ci, di;
    op = $urandom_range(0, 7);
    ci = $urandom_range(0, 15);
    di = $urandom_range(0, 15);
    if (op == OP_READ_CENTER && ci < eff(cfg_nk, MAX_CLS) && di < eff(cfg_nd, MAX_DIMS)
        && !ctr_set[ci*16+di]) op = OP_READ_ASSIGN;
    if (op == OP_RUN && !stores_ready()) op = OP_READ_ASSIGN;
    push_job(op, $urandom_range(0, 1023), ci, di, $urandom);
  endtask

  task automatic drain();
    do @(negedge clk);
    while (pending_jobs.size() != 0 || in_valid || expected_res.size() != 0);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [31:0] coord_val(int style, int grp);
    if (style == 0) return $urandom;
    return (grp << 20) + $urandom_range(0, 'h3FFFF) - 'h20000;
  endfunction

  // well-formed load, run, readback sequence with random content
  task automatic random_phase();
    int np, nk, nd, it, style;
    logic [31:0] thr;
    np = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 16);
    nk = $urandom_range(1, 4);
    nd = $urandom_range(1, 4);
    case ($urandom_range(0, 3))
      0: thr = 0;
      1: thr = 32'd4356;
      2: thr = $urandom;
      default: thr = 32'hFFFF_FFFF;
    endcase
    it = (thr == 0) ? $urandom_range(1, 3) : $urandom_range(1, 10);
    style = $urandom_range(0, 2);
    set_all(np, nk, nd, it, thr);
    for (int i = 0; i < np; i++)
      for (int d = 0; d < nd; d++) begin
        push_job(OP_LOAD_POINT, i, 0, d, coord_val(style, $urandom_range(-3, 3)));
        if ($urandom_range(0, 7) == 0) push_noise();
      end
    for (int k = 0; k < nk; k++)
      for (int d = 0; d < nd; d++)
        push_job(OP_LOAD_CENTER, 0, k, d, coord_val(style, $urandom_range(-3, 3)));
    push_job(OP_RUN, 0, 0, 0, $urandom);
    for (int i = 0; i < np; i++) push_job(OP_READ_ASSIGN, i, 0, 0, $urandom);
    for (int k = 0; k < nk; k++)
      for (int d = 0; d < nd; d++) push_job(OP_READ_CENTER, 0, k, d, $urandom);
    repeat ($urandom_range(1, 6)) push_noise();
    if ($urandom_range(0, 2) == 0) begin
      push_job(OP_LOAD_POINT, $urandom_range(0, np - 1), 0, $urandom_range(0, nd - 1),
               coord_val(style, 5));
      push_job(OP_RUN, 0, 0, 0, $urandom);
      push_job(OP_READ_ASSIGN, $urandom_range(0, np - 1), 0, 0, $urandom);
    end
    drain();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero round limit, index errors, unknown ops
    set_all(2, 2, 2, 0, 0);
    push_job(OP_LOAD_POINT, 0, 0, 0, 32'h7FFF_FFFF);
    push_job(OP_LOAD_POINT, 0, 0, 1, 32'h8000_0000);
    push_job(OP_LOAD_POINT, 1, 0, 0, 32'h0);
    push_job(OP_LOAD_POINT, 1, 0, 1, 32'hFFFF_FFFF);
    for (int k = 0; k < 2; k++)
      for (int d = 0; d < 2; d++) push_job(OP_LOAD_CENTER, 0, k, d, 32'h0);
    push_job(OP_RUN, 0, 0, 0, 0);
    push_job(OP_READ_ASSIGN, 1, 0, 0, 0);
    push_job(OP_LOAD_POINT, 2, 0, 0, 32'h1234);
    push_job(OP_LOAD_CENTER, 0, 2, 0, 32'h1234);
    push_job(OP_LOAD_CENTER, 0, 0, 2, 32'h1234);
    push_job(OP_READ_CENTER, 0, 15, 15, 0);
    push_job(OP_READ_ASSIGN, 1023, 0, 0, 0);
    for (int u = OP_READ_CENTER + 1; u < 8; u++) push_job(u, 0, 0, 0, 32'hFFFF_FFFF);
    drain();

    // threshold zero never converges; saturating shift from extreme coordinates
    cfg_write(REG_MAX_IT, 3);
    push_job(OP_RUN, 0, 0, 0, 0);
    push_job(OP_READ_ASSIGN, 0, 0, 0, 0);
    push_job(OP_READ_ASSIGN, 1, 0, 0, 0);
    for (int k = 0; k < 2; k++)
      for (int d = 0; d < 2; d++) push_job(OP_READ_CENTER, 0, k, d, 0);
    drain();

    // counts above the maximum clamp to it
    set_all(2047, 31, 31, 255, 32'hFFFF_FFFF);
    push_job(OP_LOAD_POINT, 1023, 0, 15, 32'h5555_AAAA);
    push_job(OP_LOAD_CENTER, 0, 15, 15, 32'hAAAA_5555);
    push_job(OP_READ_CENTER, 0, 15, 15, 0);
    push_job(OP_READ_ASSIGN, 1023, 0, 0, 0);
    drain();

    // zero counts act as one; a run with the largest threshold stops once the center settles
    set_all(0, 0, 0, 255, 32'hFFFF_FFFF);
    push_job(OP_LOAD_POINT, 0, 0, 0, 32'h0003_0000);
    push_job(OP_LOAD_CENTER, 0, 0, 0, 32'hFFFD_0000);
    push_job(OP_RUN, 0, 0, 0, 0);
    push_job(OP_READ_ASSIGN, 0, 0, 0, 0);
    push_job(OP_READ_ASSIGN, 1, 0, 0, 0);
    push_job(OP_READ_CENTER, 0, 0, 0, 0);
    push_job(OP_READ_CENTER, 0, 1, 0, 0);
    drain();

    while (job_count < 750) random_phase();

    if (mismatches == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
